// ----- src/rgbyuv_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbyuv_pkg
// Shared sizes, reset values and register indexes for the RGB to YUV 4:2:0
// converter.
// ----------------------------------------------------------------------------
package rgbyuv_pkg;

  // Default build sizes
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int FRAC_BITS_DEF  = 14;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int ADDR_W     = 21;

  // Size register reset values
  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

endpackage

// ----- src/rgbyuv_ram.sv -----
// ----------------------------------------------------------------------------
// rgbyuv_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when the read is enabled.
// ----------------------------------------------------------------------------
module rgbyuv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/rgb_to_yuv420_converter_core.sv -----
// A result passes through stages A, B, C, D and the output register. Throughput:
// one pixel per cycle while the output is not stalled; the line buffer
// takes one write and one read per cycle on separate ports.
// Reset: position counters and chroma history cleared, frame size registers
// set to 640 x 480. The line buffer is not cleared; an odd row reads only
// entries that the even row above it wrote.
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core
// Streaming RGB to YUV 4:2:0 converter: fixed-point BT.601 luma per pixel and
// 2x2 box-averaged chroma on every odd column of every odd row.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_core #(
  parameter int MAX_WIDTH  = rgbyuv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbyuv_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = rgbyuv_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgbyuv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbyuv_pkg::CFG_DATA_W-1:0]   cfg_data,
  // pixel input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rgbyuv_pkg::PIX_W-1:0]        red,
  input  logic [rgbyuv_pkg::PIX_W-1:0]        green,
  input  logic [rgbyuv_pkg::PIX_W-1:0]        blue,
  input  logic                                frame_start,
  // result output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rgbyuv_pkg::PIX_W-1:0]        luma,
  output logic                                chroma_valid,
  output logic [rgbyuv_pkg::PIX_W-1:0]        cb,
  output logic [rgbyuv_pkg::PIX_W-1:0]        cr,
  output logic [rgbyuv_pkg::ADDR_W-1:0]       chroma_addr,
  output logic                                frame_end
);

  localparam int PIX_W  = rgbyuv_pkg::PIX_W;
  localparam int FW_W   = rgbyuv_pkg::FW_W;
  localparam int FH_W   = rgbyuv_pkg::FH_W;
  localparam int ADDR_W = rgbyuv_pkg::ADDR_W;

  // Position and size widths
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int W_TOP = MAX_WIDTH - (MAX_WIDTH % 2);
  localparam int H_TOP = MAX_HEIGHT - (MAX_HEIGHT % 2);
  localparam int MBW   = WW + ROW_W;

  // Line buffer geometry
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Arithmetic widths
  localparam int CW    = FRAC_BITS + 1;   // coefficient magnitude
  localparam int PRW   = PIX_W + CW;      // one product
  localparam int UW    = FRAC_BITS + 8;   // clipped chroma
  localparam int PW    = FRAC_BITS + 9;   // pair sum
  localparam int QW    = FRAC_BITS + 10;  // 2x2 sum, luma sum
  localparam int ACC_W = FRAC_BITS + 11;  // signed chroma accumulator

  // Coefficients, rounded to FRAC_BITS fraction bits
  localparam longint C_YR = ((longint'(2989) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_YG = ((longint'(5866) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_YB = ((longint'(1145) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_UR = ((longint'(1688) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_UG = ((longint'(3312) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_HALF = ((longint'(5000) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_VG = ((longint'(4184) << FRAC_BITS) + 5000) / 10000;
  localparam longint C_VB = ((longint'(816) << FRAC_BITS) + 5000) / 10000;

  localparam logic [CW-1:0] K_YR   = CW'(C_YR);
  localparam logic [CW-1:0] K_YG   = CW'(C_YG);
  localparam logic [CW-1:0] K_YB   = CW'(C_YB);
  localparam logic [CW-1:0] K_UR   = CW'(C_UR);
  localparam logic [CW-1:0] K_UG   = CW'(C_UG);
  localparam logic [CW-1:0] K_HALF = CW'(C_HALF);
  localparam logic [CW-1:0] K_VG   = CW'(C_VG);
  localparam logic [CW-1:0] K_VB   = CW'(C_VB);

  localparam logic [ACC_W-1:0] OFS_FIX = ACC_W'(longint'(128) << FRAC_BITS);
  localparam logic [ACC_W-1:0] MAX_FIX = ACC_W'(longint'(255) << FRAC_BITS);

  // Clip a signed accumulator to 0 .. 255.0
  function automatic logic [UW-1:0] clip_fix(input logic [ACC_W-1:0] acc);
    logic [UW-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (acc > MAX_FIX) begin
      res = MAX_FIX[UW-1:0];
    end else begin
      res = acc[UW-1:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgbyuv_pkg::FW_RESET;
      frame_height <= rgbyuv_pkg::FH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rgbyuv_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        rgbyuv_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: even, saturated to 2 .. max
  logic [FW_W-1:0] fw_even;
  logic [FH_W-1:0] fh_even;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;

  assign fw_even = {frame_width[FW_W-1:1], 1'b0};
  assign fh_even = {frame_height[FH_W-1:1], 1'b0};

  always_comb begin
    if (fw_even < FW_W'(2)) begin
      w_eff = WW'(2);
    end else if (32'(fw_even) > W_TOP) begin
      w_eff = WW'(W_TOP);
    end else begin
      w_eff = WW'(fw_even);
    end
    if (fh_even < FH_W'(2)) begin
      h_eff = HW'(2);
    end else if (32'(fh_even) > H_TOP) begin
      h_eff = HW'(H_TOP);
    end else begin
      h_eff = HW'(fh_even);
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output register is free
  // --------------------------------------------------------------------------
  logic adv;
  logic in_xfer;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign in_xfer  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Position counters
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             col_wrap;
  logic             row_wrap;
  logic             end_cur;

  assign col_cur  = frame_start ? '0 : column_count;
  assign row_cur  = frame_start ? '0 : row_count;
  assign col_inc  = {1'b0, col_cur} + 1'b1;
  assign row_inc  = {1'b0, row_cur} + 1'b1;
  assign col_wrap = 32'(col_inc) >= 32'(w_eff);
  assign row_wrap = 32'(row_inc) >= 32'(h_eff);
  assign end_cur  = (32'(col_cur) == 32'(w_eff) - 1) && (32'(row_cur) == 32'(h_eff) - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_xfer) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_inc[ROW_W-1:0];
      end else begin
        column_count <= col_inc[COL_W-1:0];
        row_count    <= row_cur;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: captured pixel and position
  // --------------------------------------------------------------------------
  logic             a_valid;
  logic [PIX_W-1:0] a_red, a_green, a_blue;
  logic [COL_W-1:0] a_col;
  logic [ROW_W-1:0] a_row;
  logic             a_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_red   <= red;
      a_green <= green;
      a_blue  <= blue;
      a_col   <= col_cur;
      a_row   <= row_cur;
      a_end   <= end_cur;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: coefficient products and chroma row base
  // --------------------------------------------------------------------------
  logic             b_valid;
  logic [PRW-1:0]   b_yr, b_yg, b_yb;
  logic [PRW-1:0]   b_ur, b_ug, b_ub;
  logic [PRW-1:0]   b_vr, b_vg, b_vb;
  logic [MBW-1:0]   b_base;
  logic [IDX_W-1:0] b_idx;
  logic             b_odd_col;
  logic             b_odd_row;
  logic             b_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_yr      <= PRW'(a_red)   * PRW'(K_YR);
      b_yg      <= PRW'(a_green) * PRW'(K_YG);
      b_yb      <= PRW'(a_blue)  * PRW'(K_YB);
      b_ur      <= PRW'(a_red)   * PRW'(K_UR);
      b_ug      <= PRW'(a_green) * PRW'(K_UG);
      b_ub      <= PRW'(a_blue)  * PRW'(K_HALF);
      b_vr      <= PRW'(a_red)   * PRW'(K_HALF);
      b_vg      <= PRW'(a_green) * PRW'(K_VG);
      b_vb      <= PRW'(a_blue)  * PRW'(K_VB);
      b_base    <= MBW'(w_eff >> 1) * MBW'(a_row >> 1);
      b_idx     <= IDX_W'(a_col >> 1);
      b_odd_col <= a_col[0];
      b_odd_row <= a_row[0];
      b_end     <= a_end;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: sums and clipping; line buffer read lands here
  // --------------------------------------------------------------------------
  logic [QW-1:0]    sum_y;
  logic [ACC_W-1:0] acc_u;
  logic [ACC_W-1:0] acc_v;

  assign sum_y = QW'(b_yr) + QW'(b_yg) + QW'(b_yb);
  assign acc_u = OFS_FIX - ACC_W'(b_ur) - ACC_W'(b_ug) + ACC_W'(b_ub);
  assign acc_v = OFS_FIX + ACC_W'(b_vr) - ACC_W'(b_vg) - ACC_W'(b_vb);

  logic              c_valid;
  logic [PIX_W-1:0]  c_y;
  logic [UW-1:0]     c_u, c_v;
  logic [ADDR_W-1:0] c_addr;
  logic [IDX_W-1:0]  c_idx;
  logic              c_odd_col;
  logic              c_odd_row;
  logic              c_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_y       <= (sum_y > QW'(MAX_FIX)) ? PIX_W'(255) : sum_y[FRAC_BITS +: PIX_W];
      c_u       <= clip_fix(acc_u);
      c_v       <= clip_fix(acc_v);
      c_addr    <= ADDR_W'(b_base + MBW'(b_idx));
      c_idx     <= b_idx;
      c_odd_col <= b_odd_col;
      c_odd_row <= b_odd_row;
      c_end     <= b_end;
    end
  end

  // Chroma of the last even-column pixel
  logic [UW-1:0] prev_u_value;
  logic [UW-1:0] prev_v_value;
  logic [PW-1:0] pair_u;
  logic [PW-1:0] pair_v;

  assign pair_u = PW'(prev_u_value) + PW'(c_u);
  assign pair_v = PW'(prev_v_value) + PW'(c_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_u_value <= '0;
      prev_v_value <= '0;
    end else if (adv && c_valid && !c_odd_col) begin
      prev_u_value <= c_u;
      prev_v_value <= c_v;
    end
  end

  // --------------------------------------------------------------------------
  // Line buffer of even-row pair sums. Written as an even-row item leaves
  // stage C, read as an odd-row item leaves stage B. The matching reader is
  // at least two items behind, so the write always lands first.
  // --------------------------------------------------------------------------
  logic            lb_we;
  logic [2*PW-1:0] lb_rdata;

  assign lb_we = adv && c_valid && c_odd_col && !c_odd_row;

  rgbyuv_ram #(
    .WIDTH (2 * PW),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (lb_we),
    .waddr (c_idx),
    .wdata ({pair_u, pair_v}),
    .re    (adv),
    .raddr (b_idx),
    .rdata (lb_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage D: pair sums of this row next to those of the row above
  // --------------------------------------------------------------------------
  logic              d_valid;
  logic [PIX_W-1:0]  d_y;
  logic [PW-1:0]     d_pair_u, d_pair_v;
  logic [PW-1:0]     d_up_u, d_up_v;
  logic [ADDR_W-1:0] d_addr;
  logic              d_chroma;
  logic              d_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_y      <= c_y;
      d_pair_u <= pair_u;
      d_pair_v <= pair_v;
      d_up_u   <= lb_rdata[2*PW-1:PW];
      d_up_v   <= lb_rdata[PW-1:0];
      d_addr   <= c_addr;
      d_chroma <= c_odd_col && c_odd_row;
      d_end    <= c_end;
    end
  end

  // 2x2 sums; dropping FRAC_BITS + 2 bits leaves an 8-bit mean
  logic [QW-1:0] quad_u;
  logic [QW-1:0] quad_v;

  assign quad_u = QW'(d_up_u) + QW'(d_pair_u);
  assign quad_v = QW'(d_up_v) + QW'(d_pair_v);

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      luma         <= d_y;
      chroma_valid <= d_chroma;
      cb           <= d_chroma ? quad_u[QW-1:FRAC_BITS+2] : '0;
      cr           <= d_chroma ? quad_v[QW-1:FRAC_BITS+2] : '0;
      chroma_addr  <= d_chroma ? d_addr : '0;
      frame_end    <= d_end;
    end
  end

endmodule

// ----- tb/sv/rgb_to_yuv420_converter_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core_checker
// Passive checker for the RGB to YUV 4:2:0 converter. It follows the config
// and pixel transfers, computes the luma and 2x2 chroma that each pixel must
// give, and compares every output transfer with the oldest pending result.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_core_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [rgbyuv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbyuv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [rgbyuv_pkg::PIX_W-1:0]      red,
  input  logic [rgbyuv_pkg::PIX_W-1:0]      green,
  input  logic [rgbyuv_pkg::PIX_W-1:0]      blue,
  input  logic                              frame_start,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [rgbyuv_pkg::PIX_W-1:0]      luma,
  input  logic                              chroma_valid,
  input  logic [rgbyuv_pkg::PIX_W-1:0]      cb,
  input  logic [rgbyuv_pkg::PIX_W-1:0]      cr,
  input  logic [rgbyuv_pkg::ADDR_W-1:0]     chroma_addr,
  input  logic                              frame_end,
  output int                                mismatch_count,
  output int                                yuv_pending,
  output int                                pixel_count,
  output int                                chroma_count,
  output int                                frame_end_count
);

  localparam int PIX_W      = rgbyuv_pkg::PIX_W;
  localparam int ADDR_W     = rgbyuv_pkg::ADDR_W;
  localparam int FW_W       = rgbyuv_pkg::FW_W;
  localparam int FH_W       = rgbyuv_pkg::FH_W;
  localparam int FRAC       = rgbyuv_pkg::FRAC_BITS_DEF;
  localparam int LINE_DEPTH = rgbyuv_pkg::MAX_WIDTH_DEF / 2;
  localparam longint MAX_FIX    = 255 << FRAC;
  localparam longint OFFSET_FIX = 128 << FRAC;

  // Coefficient k/10000 rounded to FRAC fraction bits
  function automatic longint coef(input int k);
    longint kk;
    kk = longint'(k);
    return ((kk << FRAC) + 5000) / 10000;
  endfunction

  localparam longint K_YR = coef(2989);
  localparam longint K_YG = coef(5866);
  localparam longint K_YB = coef(1145);
  localparam longint K_UR = coef(1688);
  localparam longint K_UG = coef(3312);
  localparam longint K_HALF = coef(5000);
  localparam longint K_VG = coef(4184);
  localparam longint K_VB = coef(816);

  typedef struct packed {
    logic [PIX_W-1:0]  luma;
    logic              chroma_valid;
    logic [PIX_W-1:0]  cb;
    logic [PIX_W-1:0]  cr;
    logic [ADDR_W-1:0] chroma_addr;
    logic              frame_end;
  } yuv_t;

  // Mirror of the block state
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  int unsigned col_cnt, row_cnt, prev_u, prev_v;
  int unsigned upper_u_sum [LINE_DEPTH];
  int unsigned upper_v_sum [LINE_DEPTH];

  yuv_t yuv_results [$];
  yuv_t seen_yuv, owed_yuv;
  int errs, n_pix, n_chroma, n_fend;

  // Clear bit 0, then saturate to 2 .. max (even)
  function automatic int unsigned fit_size(input int unsigned v, input int unsigned maxv);
    int unsigned top_v;
    top_v = maxv & ~32'd1;
    v = v & ~32'd1;
    if (v < 2) v = 2;
    if (v > top_v) v = top_v;
    return v;
  endfunction

  function automatic int unsigned clip_fix(input longint acc);
    if (acc < 0) return 0;
    if (acc > MAX_FIX) return MAX_FIX[31:0];
    return acc[31:0];
  endfunction

  // Luma, box chroma and position flags for one pixel; advances the counters
  function automatic yuv_t convert_pixel(input logic [PIX_W-1:0] r, g, b, input logic fs);
    yuv_t res;
    longint rv, gv, bv, acc;
    int unsigned w, h, col, row, idx, uc, vc, pu, pv, su, sv, a, yc;
    res = '0;
    rv = longint'(r);
    gv = longint'(g);
    bv = longint'(b);
    w = fit_size(32'(width_reg), rgbyuv_pkg::MAX_WIDTH_DEF);
    h = fit_size(32'(height_reg), rgbyuv_pkg::MAX_HEIGHT_DEF);
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = col_cnt;
    row = row_cnt;

    acc = K_YR * rv + K_YG * gv + K_YB * bv;
    yc = clip_fix(acc) >> FRAC;
    res.luma = yc[PIX_W-1:0];
    acc = OFFSET_FIX - K_UR * rv - K_UG * gv + K_HALF * bv;
    uc = clip_fix(acc);
    acc = OFFSET_FIX + K_HALF * rv - K_VG * gv - K_VB * bv;
    vc = clip_fix(acc);

    // Odd column closes a pair: even rows store it, odd rows finish the block
    if (col[0]) begin
      idx = col >> 1;
      pu = prev_u + uc;
      pv = prev_v + vc;
      if (!row[0]) begin
        upper_u_sum[idx] = pu;
        upper_v_sum[idx] = pv;
      end else begin
        su = (upper_u_sum[idx] + pu) >> (FRAC + 2);
        sv = (upper_v_sum[idx] + pv) >> (FRAC + 2);
        a = (w >> 1) * (row >> 1) + idx;
        res.chroma_valid = 1'b1;
        res.cb = su[PIX_W-1:0];
        res.cr = sv[PIX_W-1:0];
        res.chroma_addr = a[ADDR_W-1:0];
      end
    end else begin
      prev_u = uc;
      prev_v = vc;
    end
    res.frame_end = (col == w - 1) && (row == h - 1);

    // Wrap also covers counters left beyond a shrunk size
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg = rgbyuv_pkg::FW_RESET;
      height_reg = rgbyuv_pkg::FH_RESET;
      col_cnt = 0;
      row_cnt = 0;
      prev_u = 0;
      prev_v = 0;
      yuv_results.delete();
      errs = 0;
      n_pix = 0;
      n_chroma = 0;
      n_fend = 0;
    end else begin
      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rgbyuv_pkg::CFG_FRAME_WIDTH:  width_reg = cfg_data[FW_W-1:0];
          rgbyuv_pkg::CFG_FRAME_HEIGHT: height_reg = cfg_data[FH_W-1:0];
          default: ;
        endcase
      end

      // Result transfer against the oldest pending result
      if (out_valid && out_ready) begin
        seen_yuv.luma = luma;
        seen_yuv.chroma_valid = chroma_valid;
        seen_yuv.cb = cb;
        seen_yuv.cr = cr;
        seen_yuv.chroma_addr = chroma_addr;
        seen_yuv.frame_end = frame_end;
        n_pix++;
        if (chroma_valid) n_chroma++;
        if (frame_end) n_fend++;
        if (yuv_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: result %0d with none pending: luma %0d cv %0d cb %0d cr %0d",
                     $time, n_pix, luma, chroma_valid, cb, cr);
        end else begin
          owed_yuv = yuv_results.pop_front();
          if (seen_yuv !== owed_yuv) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: result %0d mismatch", $time, n_pix);
              $display("  exp luma %0d cv %0d cb %0d cr %0d addr %0d fend %0d",
                       owed_yuv.luma, owed_yuv.chroma_valid, owed_yuv.cb, owed_yuv.cr,
                       owed_yuv.chroma_addr, owed_yuv.frame_end);
              $display("  got luma %0d cv %0d cb %0d cr %0d addr %0d fend %0d",
                       seen_yuv.luma, seen_yuv.chroma_valid, seen_yuv.cb, seen_yuv.cr,
                       seen_yuv.chroma_addr, seen_yuv.frame_end);
            end
          end
        end
      end

      // Pixel transfer
      if (in_valid && in_ready)
        yuv_results.push_back(convert_pixel(red, green, blue, frame_start));
    end

    mismatch_count <= errs;
    yuv_pending <= yuv_results.size();
    pixel_count <= n_pix;
    chroma_count <= n_chroma;
    frame_end_count <= n_fend;
  end

endmodule

// ----- tb/sv/rgb_to_yuv420_converter_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_core_tb
// Drives pixel streams through the converter over many frame sizes: directed
// corner colors and resyncs, the largest width and height, then random frames
// with size changes, mid-frame resyncs and random gaps and output stalls.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_core_tb;

  localparam int PIX_W      = rgbyuv_pkg::PIX_W;
  localparam int ADDR_W     = rgbyuv_pkg::ADDR_W;
  localparam int FW_W       = rgbyuv_pkg::FW_W;
  localparam int CFG_IDX_W  = rgbyuv_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rgbyuv_pkg::CFG_DATA_W;

  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 680;
  localparam int CALM_AFTER    = 560;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = rgbyuv_pkg::CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      red = '0;
  logic [PIX_W-1:0]      green = '0;
  logic [PIX_W-1:0]      blue = '0;
  logic                  frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      luma;
  logic                  chroma_valid;
  logic [PIX_W-1:0]      cb;
  logic [PIX_W-1:0]      cr;
  logic [ADDR_W-1:0]     chroma_addr;
  logic                  frame_end;

  int mismatch_count, yuv_pending, pixel_count, chroma_count, frame_end_count;
  int idle_cycles = 0;
  int covered_pairs = 0;
  int size_settings = 0;
  bit calm = 1'b0;

  rgb_to_yuv420_converter_core dut (.*);

  rgb_to_yuv420_converter_core_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output stalls in random bursts
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("rgb_to_yuv420_converter_core test failed");
        $finish;
      end
    end
  end

  // Component level biased toward the extremes
  function automatic logic [PIX_W-1:0] color_level();
    logic [PIX_W-1:0] v;
    int pick;
    pick = $urandom_range(0, 9);
    v = PIX_W'($urandom_range(0, 255));
    if (pick == 0) v = 8'h00;
    if (pick == 1) v = 8'hff;
    return v;
  endfunction

  // One pixel transfer; valid stays up afterwards unless a gap follows
  task automatic push_pixel(input logic [PIX_W-1:0] r, g, b, input logic fs);
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait for every pending result
  task automatic settle();
    in_valid <= 1'b0;
    frame_start <= 1'b0;
    @(posedge clk);
    while (yuv_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input rgbyuv_pkg::cfg_index_t idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] wdata, hdata);
    settle();
    write_reg(rgbyuv_pkg::CFG_FRAME_WIDTH, wdata);
    write_reg(rgbyuv_pkg::CFG_FRAME_HEIGHT, hdata);
    cfg_valid <= 1'b0;
    size_settings++;
  endtask

  // n random pixels at an effective size of w x h. With restart, frame_start
  // marks every frame boundary. Stray resyncs stay out of the first row of a
  // restarted run so that every line entry read was written before.
  task automatic run_frames(input int w, h, n, input bit restart);
    int frame_px;
    logic fs;
    frame_px = w * h;
    for (int p = 0; p < n; p++) begin
      fs = restart && (p % frame_px == 0);
      if ((!restart || p >= w) && $urandom_range(0, 149) == 0) fs = 1'b1;
      push_pixel(color_level(), color_level(), color_level(), fs);
    end
    if (restart && n >= w && w / 2 > covered_pairs) covered_pairs = w / 2;
  endtask

  initial begin
    int w, h, n, pick, random_done;
    bit restart;
    logic [CFG_DATA_W-1:0] wdata, hdata;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset size 640 x 480: a few pixels of row 0, no chroma
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    push_pixel(8'hff, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h00, 8'h00, 8'hff, 1'b0);

    // Out-of-range registers fold to 2 x 2; color corners drive chroma clipping
    configure(13'd1, 13'd0);
    push_pixel(8'h00, 8'h00, 8'hff, 1'b1);
    push_pixel(8'hff, 8'hff, 8'h00, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    push_pixel(8'hff, 8'h00, 8'h00, 1'b1);
    push_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    push_pixel(8'h00, 8'hff, 8'hff, 1'b0);
    push_pixel(8'hff, 8'h00, 8'hff, 1'b0);
    // Resync in the middle of a frame
    push_pixel(8'd10, 8'd20, 8'd30, 1'b1);
    push_pixel(8'd200, 8'd100, 8'd50, 1'b0);
    push_pixel(8'd7, 8'd7, 8'd7, 1'b1);
    push_pixel(8'd1, 8'd2, 8'd3, 1'b0);
    push_pixel(8'd250, 8'd240, 8'd230, 1'b0);
    push_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    covered_pairs = 1;

    // Widest line: 4095 saturates to 2048; the start of row 0 fills pairs 0 .. 31
    configure(13'd4095, 13'd3);
    run_frames(2048, 2, 64, 1'b1);
    covered_pairs = 32;
    // Tallest frame: 8191 saturates to 4096
    configure(13'd2, 13'd8191);
    run_frames(2, 4096, 64, 1'b1);
    // Shrink without resync: the row count sits beyond the new height
    configure(13'd6, 13'd4);
    run_frames(6, 4, 30, 1'b0);

    // Random frames and size changes
    random_done = 0;
    while (random_done < RANDOM_PIXELS) begin
      calm = (random_done >= CALM_AFTER);
      pick = $urandom_range(0, 9);
      if (pick < 6) w = 2 * $urandom_range(1, 6);
      else if (pick < 9) w = 2 * $urandom_range(7, 40);
      else w = 2 * $urandom_range(41, 200);
      if ($urandom_range(0, 4) == 0) h = 2 * $urandom_range(6, 30);
      else h = 2 * $urandom_range(1, 4);
      if (w * h <= 96) n = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
      else n = $urandom_range(w, 3 * w);
      if (n > 400) n = 400;
      if (n > RANDOM_PIXELS - random_done) n = RANDOM_PIXELS - random_done;
      restart = !(w / 2 <= covered_pairs && $urandom_range(0, 3) == 0);
      wdata = CFG_DATA_W'(w | $urandom_range(0, 1));
      wdata[FW_W] = 1'($urandom_range(0, 1));
      hdata = CFG_DATA_W'(h | $urandom_range(0, 1));
      configure(wdata, hdata);
      run_frames(w, h, n, restart);
      random_done += n;
    end

    // Drain and let any stray output show up
    settle();
    repeat (10) @(posedge clk);

    $display("Covered %0d pixel results, %0d chroma blocks and %0d frame ends", pixel_count,
             chroma_count, frame_end_count);
    $display("over %0d frame sizes, from 2 x 2 up to 2048 columns and 4096 rows.", size_settings);
    if (mismatch_count == 0 && yuv_pending == 0)
      $display("rgb_to_yuv420_converter_core test passed");
    else
      $display("rgb_to_yuv420_converter_core test failed");
    $finish;
  end

endmodule
